@@ rtl/pcc_pkg.sv @@
// ============================================================================
// pcc_pkg - shared definitions for the permutation / combination counter
// Holds the sequencer states, the status codes and the fixed field widths.
// ============================================================================
package pcc_pkg;

   // Default width of the count field.
   localparam int DEF_RESULT_BITS = 31;

   // Width of the signed set and subset size fields.
   localparam int SIZE_W = 32;

   // A factor of the falling product is a positive 32-bit value, so 31 bits.
   localparam int FACTOR_W = 31;

   // The shared multiplier takes one digit of the factor per pass.
   localparam int DIGIT_W = 16;

   // Status codes returned with each result item.
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_SIZE     = 2'd1;
   localparam logic [1:0] STATUS_SUBSET   = 2'd2;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd3;

   // Sequencer states.
   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL_LO,
      S_MUL_HI,
      S_MUL_ACC,
      S_DIV,
      S_DONE
   } state_type;

endpackage

@@ rtl/permutation_combination_count.sv @@
// ============================================================================
// permutation_combination_count - exact nPr / nCr calculator
// Returns P(n,k) or C(n,k) with a status for each request item.
// ============================================================================
// Each request item carries n, k and an action bit; the block answers with one
// result item holding the count and a status. The sizes are checked first:
// n or k below one gives status 1, k above n gives status 2. Otherwise P(n,k)
// is formed as the exact falling product n*(n-1)*...*(n-k+1) on one shared
// multiplier, which takes each factor in turn through a low digit, a high
// digit and an accumulate and overflow test step. A product beyond
// 2^RESULT_BITS-1 stops the work at once with status 3, which also applies
// to combinations. For combinations, k! is then formed on the same
// multiplier in the same way, and P is divided by it in a restoring divider
// that yields one quotient bit per cycle. The block takes one item at a
// time: req_tready is high only while it is idle, and a finished result
// sits in an output register, so a new item may be taken while the previous
// result still waits for rsp_tready.
module permutation_combination_count #(
   parameter int RESULT_BITS = pcc_pkg::DEF_RESULT_BITS,
   localparam int RSP_DATA_W = ((RESULT_BITS + 7) / 8) * 8
) (
   input  logic                    clock,
   input  logic                    reset,
   // Request channel.
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // Fields from bit 0 up: set_size [31:0], subset_size [63:32].
   input  logic [2*pcc_pkg::SIZE_W-1:0] req_tdata,
   // Fields from bit 0 up: action [0] (0 permutations, 1 combinations).
   input  logic [0:0]              req_tuser,
   // Result channel.
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // Fields from bit 0 up: count [RESULT_BITS-1:0], zero padding above.
   output logic [RSP_DATA_W-1:0]   rsp_tdata,
   // Fields from bit 0 up: status [1:0].
   output logic [1:0]              rsp_tuser
);

   import pcc_pkg::*;

   localparam int MUL_W  = RESULT_BITS + DIGIT_W;
   localparam int PROD_W = RESULT_BITS + FACTOR_W;
   localparam int CNT_W  = FACTOR_W;

   // Sequencer and output registers (control ones are reset).
   state_type                state_ff, state_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RESULT_BITS-1:0]   rsp_count_ff, rsp_count_in;
   logic [1:0]               rsp_status_ff, rsp_status_in;

   // Working registers.
   logic                     action_ff, action_in;
   logic                     phase_ff, phase_in;       // 0 forms P, 1 forms k!
   logic [RESULT_BITS-1:0]   acc_ff, acc_in;           // running product, divisor
   logic [RESULT_BITS-1:0]   perm_ff, perm_in;         // P, then quotient, result
   logic [RESULT_BITS:0]     rem_ff, rem_in;           // division remainder
   logic [FACTOR_W-1:0]      fac_ff, fac_in;           // current factor
   logic [FACTOR_W-1:0]      kval_ff, kval_in;         // k, kept to start k!
   logic [CNT_W-1:0]         left_ff, left_in;         // steps still to go
   logic [MUL_W-1:0]         lo_ff, lo_in;
   logic [MUL_W-1:0]         hi_ff, hi_in;
   logic [1:0]               status_ff, status_in;

   // Shared multiplier and datapath signals.
   logic [DIGIT_W-1:0]       mul_digit;
   logic [MUL_W-1:0]         mul_res;
   logic [PROD_W-1:0]        prod_sum;
   logic                     prod_ovf;
   logic [RESULT_BITS:0]     rem_shift;
   logic [RESULT_BITS:0]     rem_diff;
   logic                     quo_bit;
   logic signed [SIZE_W-1:0] n_in;
   logic signed [SIZE_W-1:0] k_in;
   logic                     req_fire;

   assign n_in     = signed'(req_tdata[SIZE_W-1:0]);
   assign k_in     = signed'(req_tdata[2*SIZE_W-1:SIZE_W]);
   assign req_fire = req_tvalid && req_tready;

   // The low pass multiplies by the low digit of the factor, the high pass by
   // the remaining upper bits.
   assign mul_digit = (state_ff == S_MUL_LO) ? fac_ff[DIGIT_W-1:0]
                    : DIGIT_W'(fac_ff[FACTOR_W-1:DIGIT_W]);
   assign mul_res   = MUL_W'(acc_ff) * MUL_W'(mul_digit);

   // Recombine both partial products; any bit at or above RESULT_BITS means
   // the product is past the limit.
   assign prod_sum = PROD_W'(lo_ff) + (PROD_W'(hi_ff) << DIGIT_W);
   assign prod_ovf = |prod_sum[PROD_W-1:RESULT_BITS];

   // One restoring division step: shift in the next dividend bit, subtract
   // the divisor when it fits.
   assign rem_shift = {rem_ff[RESULT_BITS-1:0], perm_ff[RESULT_BITS-1]};
   assign rem_diff  = rem_shift - {1'b0, acc_ff};
   assign quo_bit   = (rem_shift >= {1'b0, acc_ff});

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      action_in     = action_ff;
      phase_in      = phase_ff;
      acc_in        = acc_ff;
      perm_in       = perm_ff;
      rem_in        = rem_ff;
      fac_in        = fac_ff;
      kval_in       = kval_ff;
      left_in       = left_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      status_in     = status_ff;
      req_tready    = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_fire) begin
               action_in = req_tuser[0];
               perm_in   = '0;
               if (n_in < 1 || k_in < 1) begin
                  status_in = STATUS_SIZE;
                  state_in  = S_DONE;
               end else if (k_in > n_in) begin
                  status_in = STATUS_SUBSET;
                  state_in  = S_DONE;
               end else begin
                  status_in = STATUS_OK;
                  acc_in    = RESULT_BITS'(1);
                  fac_in    = n_in[FACTOR_W-1:0];
                  kval_in   = k_in[FACTOR_W-1:0];
                  left_in   = k_in[CNT_W-1:0];
                  phase_in  = 1'b0;
                  state_in  = S_MUL_LO;
               end
            end
         end

         S_MUL_LO: begin
            lo_in    = mul_res;
            state_in = S_MUL_HI;
         end

         S_MUL_HI: begin
            hi_in    = mul_res;
            state_in = S_MUL_ACC;
         end

         S_MUL_ACC: begin
            if (prod_ovf) begin
               // Only the falling product can get here; k! never exceeds P.
               status_in = STATUS_OVERFLOW;
               perm_in   = '0;
               state_in  = S_DONE;
            end else begin
               acc_in  = prod_sum[RESULT_BITS-1:0];
               fac_in  = fac_ff - FACTOR_W'(1);
               left_in = left_ff - CNT_W'(1);
               if (left_ff == CNT_W'(1)) begin
                  if (!phase_ff) begin
                     perm_in = prod_sum[RESULT_BITS-1:0];
                     if (!action_ff) begin
                        state_in = S_DONE;
                     end else begin
                        // Start k! = k*(k-1)*...*1 on the same multiplier.
                        acc_in   = RESULT_BITS'(1);
                        fac_in   = kval_ff;
                        left_in  = kval_ff;
                        phase_in = 1'b1;
                        state_in = S_MUL_LO;
                     end
                  end else begin
                     // k! is now the divisor in acc; P is the dividend.
                     rem_in   = '0;
                     left_in  = CNT_W'(RESULT_BITS);
                     state_in = S_DIV;
                  end
               end else begin
                  state_in = S_MUL_LO;
               end
            end
         end

         S_DIV: begin
            rem_in  = quo_bit ? rem_diff : rem_shift;
            perm_in = {perm_ff[RESULT_BITS-2:0], quo_bit};
            left_in = left_ff - CNT_W'(1);
            if (left_ff == CNT_W'(1)) begin
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_count_in  = perm_ff;
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
      action_ff     <= action_in;
      phase_ff      <= phase_in;
      acc_ff        <= acc_in;
      perm_ff       <= perm_in;
      rem_ff        <= rem_in;
      fac_ff        <= fac_in;
      kval_ff       <= kval_in;
      left_ff       <= left_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      status_ff     <= status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_count_ff);
   assign rsp_tuser  = rsp_status_ff;

endmodule
